// File: hw/rtl/slt_pkg.sv
// Shared types and constants for the seat lease table.
package slt_pkg;

    // Request codes carried in the input tuser field.
    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_STATE      = 4'd1,
        CMD_JOIN       = 4'd2,
        CMD_LEAVE      = 4'd3,
        CMD_MOVE       = 4'd4,
        CMD_DIR        = 4'd5,
        CMD_BTN        = 4'd6,
        CMD_PING       = 4'd7,
        CMD_TAKE_PRESS = 4'd8
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_SEAT_COUNT = 1'b0,
        REG_TIMEOUT    = 1'b1
    } reg_index_t;

    // Direction codes that change a heading.
    localparam logic [2:0] DIR_UP   = 3'd1;
    localparam logic [2:0] DIR_LEFT = 3'd4;

    localparam logic [6:0]  POS_MAX       = 7'd100;
    localparam logic [6:0]  POS_RESET     = 7'd50;
    localparam logic [1:0]  PRESS_MAX     = 2'd3;
    localparam logic [15:0] AGE_MAX       = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd9000;

    // Request as seen by one seat.
    typedef struct packed {
        cmd_t        cmd;
        logic        sel;       // seat addressed and within seat_count
        logic        take_sel;  // seat addressed by a take_press
        logic        in_count;  // seat lies below seat_count
        logic [15:0] timeout;
        logic [15:0] position;  // two's complement
        logic [2:0]  direction;
    } seat_req_t;

    // Facts about one seat before the update.
    typedef struct packed {
        logic owner_ok;
        logic press_any;
        logic released;
    } seat_flags_t;

    // Seat status after the update.
    typedef struct packed {
        logic       held;
        logic [6:0] position;
        logic [2:0] heading;
    } seat_stat_t;

endpackage

// File: hw/rtl/slt_seat.sv
// State and update logic of one leased seat.
module slt_seat #(
    parameter int TOKEN_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  slt_pkg::seat_req_t      req,
    input  logic [TOKEN_BITS-1:0]   token,
    output slt_pkg::seat_flags_t    flags,
    output slt_pkg::seat_stat_t     stat_next
);
    import slt_pkg::*;

    logic                  held_reg,    held_next;
    logic [TOKEN_BITS-1:0] owner_reg,   owner_next;
    logic [15:0]           age_reg,     age_next;
    logic [6:0]            pos_reg,     pos_next;
    logic [2:0]            heading_reg, heading_next;
    logic [1:0]            presses_reg, presses_next;

    logic        owner_ok;
    logic        released;
    logic [15:0] age_inc;
    logic [6:0]  pos_clamped;

    // Ownership check, saturating age and position clamp.
    always_comb
    begin
        owner_ok = held_reg && (owner_reg == token);
        age_inc  = (age_reg == AGE_MAX) ? age_reg : age_reg + 16'd1;
        if (req.position[15])
            pos_clamped = 7'd0;
        else if ($signed(req.position) > $signed({9'd0, POS_MAX}))
            pos_clamped = POS_MAX;
        else
            pos_clamped = req.position[6:0];
    end

    // Next state for the request in hand.
    always_comb
    begin
        held_next    = held_reg;
        owner_next   = owner_reg;
        age_next     = age_reg;
        pos_next     = pos_reg;
        heading_next = heading_reg;
        presses_next = presses_reg;
        released     = 1'b0;
        case (req.cmd)
            CMD_TICK:
            begin
                age_next = age_inc;
                if (req.in_count && held_reg && (age_inc > req.timeout))
                begin
                    held_next  = 1'b0;
                    owner_next = '0;
                    released   = 1'b1;
                end
            end
            CMD_JOIN:
            begin
                if (req.sel && (!held_reg || (owner_reg == token)))
                begin
                    held_next  = 1'b1;
                    owner_next = token;
                    age_next   = 16'd0;
                end
            end
            CMD_LEAVE:
            begin
                if (req.sel && owner_ok)
                begin
                    held_next  = 1'b0;
                    owner_next = '0;
                end
            end
            CMD_MOVE, CMD_DIR, CMD_BTN, CMD_PING:
            begin
                if (req.sel && owner_ok)
                begin
                    age_next = 16'd0;
                    if (req.cmd == CMD_MOVE)
                        pos_next = pos_clamped;
                    if ((req.cmd == CMD_DIR) && (req.direction inside {[DIR_UP:DIR_LEFT]}))
                        heading_next = req.direction;
                    if ((req.cmd == CMD_BTN) && (presses_reg < PRESS_MAX))
                        presses_next = presses_reg + 2'd1;
                end
            end
            CMD_TAKE_PRESS:
            begin
                if (req.take_sel && (presses_reg != 2'd0))
                    presses_next = presses_reg - 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    // Seat state registers, updated once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= 1'b0;
            owner_reg   <= '0;
            age_reg     <= 16'd0;
            pos_reg     <= POS_RESET;
            heading_reg <= 3'd0;
            presses_reg <= 2'd0;
        end
        else if (step)
        begin
            held_reg    <= held_next;
            owner_reg   <= owner_next;
            age_reg     <= age_next;
            pos_reg     <= pos_next;
            heading_reg <= heading_next;
            presses_reg <= presses_next;
        end
    end

    // Report to the top level.
    always_comb
    begin
        flags.owner_ok     = owner_ok;
        flags.press_any    = (presses_reg != 2'd0);
        flags.released     = released;
        stat_next.held     = held_next;
        stat_next.position = pos_next;
        stat_next.heading  = heading_next;
    end

endmodule

// File: hw/rtl/seat_lease_table.sv
// Top level of the two-seat lease table with stream ports and a register write port.
//
// Every request or tick takes one input transfer and yields exactly one result
// transfer. The block takes one item in every clock cycle while the output is not
// stalled: an item is held in the input register, all seats are updated in
// parallel from it and the result lands in the output register, which drives
// m_tvalid. The result register is the only limit on rate; s_tready depends
// combinationally on m_tready when both registers are full. The status fields
// show the seats after the request.
module seat_lease_table #(
    parameter int SEATS      = 2,
    parameter int TOKEN_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // seat[1:0], token[33:2], position[49:34],
                                  // direction[52:50], zero fill [55:53]
    input  logic [3:0]  s_tuser,  // command[3:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // accepted[0], broadcast[1], seat_one_taken[2],
                                  // seat_two_taken[3], seat_one_position[10:4],
                                  // seat_two_position[17:11], seat_one_heading[20:18],
                                  // seat_two_heading[23:21]
);
    import slt_pkg::*;

    // Configuration registers.
    logic [1:0]  count_reg;
    logic [15:0] timeout_reg;
    logic [1:0]  count_wr;

    // Input register.
    logic        in_valid_reg, in_valid_next;
    logic [3:0]  cmd_reg;
    logic [1:0]  seat_reg;
    logic [31:0] token_reg;
    logic [15:0] pos_reg;
    logic [2:0]  dir_reg;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg;
    logic [23:0] result;

    logic                  advance;
    logic [63:0]           token_wide;
    logic [TOKEN_BITS-1:0] token_masked;
    cmd_t                  cmd;

    logic [SEATS-1:0] sel_vec;
    logic [SEATS-1:0] take_sel_vec;
    logic [SEATS-1:0] owner_vec;
    logic [SEATS-1:0] press_vec;
    logic [SEATS-1:0] released_vec;
    seat_flags_t      flags  [SEATS];
    seat_stat_t       stat   [SEATS];
    seat_req_t        req    [SEATS];

    logic       accepted;
    logic       broadcast;
    logic       two_taken;
    logic [6:0] two_position;
    logic [2:0] two_heading;

    // Handshake: a stored item moves on when the result register is empty or its result is taken.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign cmd          = cmd_t'(cmd_reg);
    assign token_wide   = {32'd0, token_reg};
    assign token_masked = token_wide[TOKEN_BITS-1:0];

    // A seat count above the number of seats saturates.
    assign count_wr = ({2'b00, cfg_data[1:0]} > 4'(SEATS)) ? 2'(SEATS) : cfg_data[1:0];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 2'd0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_SEAT_COUNT: count_reg   <= count_wr;
                REG_TIMEOUT:    timeout_reg <= cfg_data;
                default:        count_reg   <= count_reg;
            endcase
        end
    end

    // Valid flags of both registers.
    always_comb
    begin
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload capture on each input transfer.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg   <= s_tuser;
            seat_reg  <= s_tdata[1:0];
            token_reg <= s_tdata[33:2];
            pos_reg   <= s_tdata[49:34];
            dir_reg   <= s_tdata[52:50];
        end
    end

    // One update unit per seat.
    for (genvar i = 0; i < SEATS; i++)
    begin : g_seat
        assign take_sel_vec[i] = ({2'b00, seat_reg} == 4'(i + 1));
        assign sel_vec[i]      = take_sel_vec[i] && (seat_reg <= count_reg);

        always_comb
        begin
            req[i].cmd       = cmd;
            req[i].sel       = sel_vec[i];
            req[i].take_sel  = take_sel_vec[i];
            req[i].in_count  = (4'(i) < {2'b00, count_reg});
            req[i].timeout   = timeout_reg;
            req[i].position  = pos_reg;
            req[i].direction = dir_reg;
        end

        slt_seat #(
            .TOKEN_BITS (TOKEN_BITS)
        ) u_seat (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (advance),
            .req       (req[i]),
            .token     (token_masked),
            .flags     (flags[i]),
            .stat_next (stat[i])
        );

        assign owner_vec[i]    = flags[i].owner_ok;
        assign press_vec[i]    = flags[i].press_any;
        assign released_vec[i] = flags[i].released;
    end

    // Outcome of the request, judged on the state before the update.
    always_comb
    begin
        accepted  = 1'b0;
        broadcast = 1'b0;
        if (cmd == CMD_TICK)
        begin
            accepted  = 1'b1;
            broadcast = |released_vec;
        end
        else if (cmd == CMD_TAKE_PRESS)
        begin
            accepted = |(press_vec & take_sel_vec);
        end
        else if ((cmd_reg > 4'(CMD_TAKE_PRESS)) || (count_reg == 2'd0))
        begin
            accepted = 1'b0;
        end
        else if (cmd == CMD_STATE)
        begin
            accepted  = 1'b1;
            broadcast = 1'b1;
        end
        else if (!(|sel_vec))
        begin
            accepted = 1'b0;
        end
        else if (cmd == CMD_JOIN)
        begin
            accepted  = 1'b1;
            broadcast = 1'b1;
        end
        else if (!(|(owner_vec & sel_vec)))
        begin
            accepted = 1'b0;
        end
        else if (cmd == CMD_LEAVE)
        begin
            accepted  = 1'b1;
            broadcast = 1'b1;
        end
        else
        begin
            accepted = 1'b1;
        end
    end

    // Second seat status; fixed values when only one seat is built.
    if (SEATS > 1)
    begin : g_two
        assign two_taken    = stat[1].held && (count_reg >= 2'd2);
        assign two_position = stat[1].position;
        assign two_heading  = stat[1].heading;
    end
    else
    begin : g_one
        assign two_taken    = 1'b0;
        assign two_position = POS_RESET;
        assign two_heading  = 3'd0;
    end

    assign result = {two_heading, stat[0].heading, two_position, stat[0].position,
                     two_taken, stat[0].held && (count_reg >= 2'd1), broadcast, accepted};

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

endmodule

// File: hw/rtl/slt_checker.sv
// Port-level checks for the seat lease table and their bind to the top level.
module slt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

    // A status message is only sent for a handled request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
    else $error("broadcast without acceptance");

    // Positions stay within percent and headings within the known codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:4] <= 7'd100) && (m_tdata[17:11] <= 7'd100)
                     && (m_tdata[20:18] <= 3'd4) && (m_tdata[23:21] <= 3'd4))
    else $error("seat status out of range");

    // With the result register empty the block always takes a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input refused while output empty");

endmodule

bind seat_lease_table slt_checker u_slt_checker (.*);

// File: sim/seat_lease_table_test.sv
// Self-checking testbench for the seat lease table: directed and random request streams.
module seat_lease_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam int         IDLE_LIMIT       = 2000;
    localparam int         SEAT_TOTAL       = 2;
    localparam int         LONG_TICK_BURST  = 24;
    localparam bit [3:0]   CMD_UNKNOWN_LAST = 4'd15;
    localparam bit [2:0]   DIR_NONE         = 3'd0;
    localparam bit [2:0]   DIR_INVALID      = 3'd7;
    localparam bit [15:0]  TIMEOUT_LONGEST  = 16'hFFFF;

    // One request as it travels on the input stream.
    typedef struct packed {
        bit [3:0]         command;
        bit [1:0]         seat;
        bit [31:0]        token;
        bit signed [15:0] position;
        bit [2:0]         direction;
    } seat_request_t;

    // One result, laid out as on m_tdata with accepted in bit 0.
    typedef struct packed {
        logic [2:0] two_heading;
        logic [2:0] one_heading;
        logic [6:0] two_position;
        logic [6:0] one_position;
        logic       two_taken;
        logic       one_taken;
        logic       broadcast;
        logic       accepted;
    } lease_status_t;

    // Lease table predictor and the queue of status words still to arrive.
    class lease_scoreboard;
        bit [1:0]      seats_in_use;
        bit [15:0]     timeout_ticks;
        bit            held [SEAT_TOTAL];
        bit [31:0]     owner [SEAT_TOTAL];
        bit [15:0]     silence [SEAT_TOTAL];
        bit [6:0]      position [SEAT_TOTAL];
        bit [2:0]      heading [SEAT_TOTAL];
        bit [1:0]      presses [SEAT_TOTAL];
        lease_status_t expected_status [$];
        int            mismatches;
        int            results_checked;
        int            releases;
        int            presses_taken;

        function new();
            seats_in_use  = 0;
            timeout_ticks = TIMEOUT_RESET;
            for (int i = 0; i < SEAT_TOTAL; i++)
            begin
                held[i]     = 0;
                owner[i]    = 0;
                silence[i]  = 0;
                position[i] = POS_RESET;
                heading[i]  = 0;
                presses[i]  = 0;
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void write_register(reg_index_t idx, bit [15:0] value);
            case (idx)
                REG_SEAT_COUNT: seats_in_use = (value[1:0] > SEAT_TOTAL) ? 2'(SEAT_TOTAL)
                                                                          : value[1:0];
                REG_TIMEOUT:    timeout_ticks = value;
                default: ;
            endcase
        endfunction

        // Apply one transferred request to the table and queue the status it yields.
        function void note_request(seat_request_t r);
            lease_status_t st;
            bit            acc;
            bit            bc;
            int            k;
            acc = 0;
            bc  = 0;
            k   = int'(r.seat) - 1;
            if (r.command == CMD_TICK)
            begin
                // Every seat ages; only seats in use can be released.
                acc = 1;
                for (int i = 0; i < SEAT_TOTAL; i++)
                begin
                    if (silence[i] != AGE_MAX)
                        silence[i]++;
                    if (i < seats_in_use && held[i] && silence[i] > timeout_ticks)
                    begin
                        held[i]  = 0;
                        owner[i] = 0;
                        bc       = 1;
                        releases++;
                    end
                end
            end
            else if (r.command == CMD_TAKE_PRESS)
            begin
                // Only the seat number matters here, not the token or the seat count.
                if (r.seat >= 1 && r.seat <= SEAT_TOTAL)
                begin
                    if (presses[k] != 0)
                    begin
                        presses[k]--;
                        acc = 1;
                        presses_taken++;
                    end
                end
            end
            else if (r.command > CMD_TAKE_PRESS || seats_in_use == 0)
            begin
                // Unknown code, or the table is switched off.
            end
            else if (r.command == CMD_STATE)
            begin
                acc = 1;
                bc  = 1;
            end
            else if (r.seat == 0 || r.seat > seats_in_use)
            begin
                // Seat outside the range in use.
            end
            else if (r.command == CMD_JOIN)
            begin
                // A seat held by someone else is left alone but still answered.
                if (!held[k] || owner[k] == r.token)
                begin
                    held[k]    = 1;
                    owner[k]   = r.token;
                    silence[k] = 0;
                end
                acc = 1;
                bc  = 1;
            end
            else if (!held[k] || owner[k] != r.token)
            begin
                // Only the holder may act on a seat.
            end
            else if (r.command == CMD_LEAVE)
            begin
                held[k]  = 0;
                owner[k] = 0;
                acc      = 1;
                bc       = 1;
            end
            else
            begin
                silence[k] = 0;
                case (r.command)
                    CMD_MOVE:
                    begin
                        if (r.position < 0)
                            position[k] = 0;
                        else if (r.position > int'(POS_MAX))
                            position[k] = POS_MAX;
                        else
                            position[k] = r.position[6:0];
                    end
                    CMD_DIR:
                    begin
                        if (r.direction >= DIR_UP && r.direction <= DIR_LEFT)
                            heading[k] = r.direction;
                    end
                    CMD_BTN:
                    begin
                        if (presses[k] < PRESS_MAX)
                            presses[k]++;
                    end
                    default: ;
                endcase
                acc = 1;
            end
            st.accepted     = acc;
            st.broadcast    = bc;
            st.one_taken    = held[0] && seats_in_use >= 1;
            st.two_taken    = held[1] && seats_in_use >= 2;
            st.one_position = position[0];
            st.two_position = position[1];
            st.one_heading  = heading[0];
            st.two_heading  = heading[1];
            expected_status.insert(expected_status.size(), st);
        endfunction

        // Compare one result transfer with the oldest outstanding status.
        function void check_result(lease_status_t got);
            lease_status_t exp;
            string         diffs;
            if (expected_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %h arrived with no request outstanding",
                             $realtime, got);
                return;
            end
            exp = expected_status.pop_front();
            results_checked++;
            diffs = "";
            if (got.accepted !== exp.accepted)         diffs = {diffs, " accepted"};
            if (got.broadcast !== exp.broadcast)       diffs = {diffs, " broadcast"};
            if (got.one_taken !== exp.one_taken)       diffs = {diffs, " seat_one_taken"};
            if (got.two_taken !== exp.two_taken)       diffs = {diffs, " seat_two_taken"};
            if (got.one_position !== exp.one_position) diffs = {diffs, " seat_one_position"};
            if (got.two_position !== exp.two_position) diffs = {diffs, " seat_two_position"};
            if (got.one_heading !== exp.one_heading)   diffs = {diffs, " seat_one_heading"};
            if (got.two_heading !== exp.two_heading)   diffs = {diffs, " seat_two_heading"};
            if (diffs != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result %0d differs in%s", $realtime, results_checked, diffs);
                    $display("    expected acc=%0d bc=%0d taken=%0d/%0d pos=%0d/%0d head=%0d/%0d",
                             exp.accepted, exp.broadcast, exp.one_taken, exp.two_taken,
                             exp.one_position, exp.two_position, exp.one_heading,
                             exp.two_heading);
                    $display("    actual   acc=%0d bc=%0d taken=%0d/%0d pos=%0d/%0d head=%0d/%0d",
                             got.accepted, got.broadcast, got.one_taken, got.two_taken,
                             got.one_position, got.two_position, got.one_heading,
                             got.two_heading);
                end
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;  // seat[1:0], token[33:2], position[49:34],
                                  // direction[52:50], zero fill [55:53]
    logic [3:0]  s_tuser   = '0;  // command[3:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;         // accepted[0], broadcast[1], seat_one_taken[2],
                                  // seat_two_taken[3], seat_one_position[10:4],
                                  // seat_two_position[17:11], seat_one_heading[20:18],
                                  // seat_two_heading[23:21]

    lease_scoreboard sb;
    bit              idling      = 1'b1;
    int              stall_left  = 0;
    int              quiet_count = 0;
    int              settings    = 0;
    int              requests    = 0;
    bit [31:0]       token_pool [3];

    seat_lease_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Receiver side: random stalls on m_tready while idling is enabled.
    always @(negedge clk)
    begin
        if (!idling)
            m_tready = 1'b1;
        else if (stall_left > 0)
        begin
            m_tready = 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready = 1'b1;
            if ($urandom_range(0, 2) == 0)
                stall_left = pick_gap();
        end
    end

    // Monitor: register writes, result transfers, request transfers and the watchdog.
    always @(posedge clk)
    begin
        seat_request_t r;
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_register(reg_index_t'(cfg_index), cfg_data);
            if (m_tvalid && m_tready)
                sb.check_result(lease_status_t'(m_tdata));
            if (s_tvalid && s_tready)
            begin
                r.command   = s_tuser;
                r.seat      = s_tdata[1:0];
                r.token     = s_tdata[33:2];
                r.position  = s_tdata[49:34];
                r.direction = s_tdata[52:50];
                sb.note_request(r);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, sb.pending());
            $display("seat_lease_table_test: FAIL");
            $finish;
        end
    end

    // Drive one request and hold it until the block takes it.
    task automatic issue(bit [3:0] command, bit [1:0] seat, bit [31:0] token,
                         bit signed [15:0] position, bit [2:0] direction);
        int gap;
        gap = idling ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = command;
        s_tdata  = {3'b000, direction, position, token, seat};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        requests++;
    endtask

    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic program_register(reg_index_t idx, bit [15:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        settings++;
    endtask

    // Random request, mostly from a small set of clients so that leases build up.
    task automatic issue_random();
        int        r;
        bit [3:0]  command;
        bit [1:0]  seat;
        bit [31:0] token;
        int        pos;
        r = $urandom_range(0, 99);
        if (r < 20)      command = CMD_TICK;
        else if (r < 25) command = CMD_STATE;
        else if (r < 42) command = CMD_JOIN;
        else if (r < 50) command = CMD_LEAVE;
        else if (r < 62) command = CMD_MOVE;
        else if (r < 72) command = CMD_DIR;
        else if (r < 82) command = CMD_BTN;
        else if (r < 87) command = CMD_PING;
        else if (r < 97) command = CMD_TAKE_PRESS;
        else             command = 4'($urandom_range(CMD_TAKE_PRESS + 1, CMD_UNKNOWN_LAST));
        seat  = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                            : 2'($urandom_range(1, 2));
        token = ($urandom_range(0, 99) < 85) ? token_pool[$urandom_range(0, 2)] : $urandom;
        case ($urandom_range(0, 3))
            0, 1:    pos = $urandom_range(0, 100);
            2:       pos = int'($urandom_range(0, 110)) - 5;
            default: pos = $urandom_range(0, 65535);
        endcase
        issue(command, seat, token, pos[15:0], 3'($urandom_range(0, 7)));
    endtask

    initial
    begin
        int        phase_seats [5]    = '{2, 1, 0, 3, 2};
        int        phase_timeout [5]  = '{4, 2, 9000, 1, 7};
        int        phase_items [5]    = '{140, 110, 40, 120, 140};
        bit [31:0] tok_a;
        bit [31:0] tok_b;

        sb = new();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: the table starts switched off, then comes up with both seats.
        tok_a = 32'hFFFF_FFFF;
        tok_b = 32'h0000_0000;
        issue(CMD_JOIN, 2'd1, tok_a, 16'sd0, DIR_NONE);
        issue(CMD_TAKE_PRESS, 2'd1, tok_a, 16'sd0, DIR_NONE);
        wait_for_results();
        program_register(REG_SEAT_COUNT, 16'd3);
        program_register(REG_TIMEOUT, 16'd2);
        issue(CMD_JOIN, 2'd1, tok_a, 16'sd0, DIR_NONE);
        issue(CMD_JOIN, 2'd1, tok_b, 16'sd0, DIR_NONE);
        issue(CMD_JOIN, 2'd2, tok_b, 16'sd0, DIR_NONE);
        issue(CMD_JOIN, 2'd0, tok_a, 16'sd0, DIR_NONE);
        issue(CMD_MOVE, 2'd1, tok_a, -16'sd32768, DIR_NONE);
        issue(CMD_MOVE, 2'd2, tok_b, 16'sd32767, DIR_NONE);
        issue(CMD_DIR, 2'd1, tok_a, 16'sd0, DIR_LEFT);
        issue(CMD_DIR, 2'd1, tok_a, 16'sd0, DIR_INVALID);
        repeat (4) issue(CMD_BTN, 2'd1, tok_a, 16'sd0, DIR_UP);
        issue(CMD_PING, 2'd2, tok_a, 16'sd0, DIR_NONE);
        issue(CMD_MOVE, 2'd1, tok_b, 16'sd55, DIR_NONE);
        repeat (4) issue(CMD_TAKE_PRESS, 2'd1, tok_b, 16'sd0, DIR_NONE);
        issue(CMD_TAKE_PRESS, 2'd3, tok_a, 16'sd0, DIR_NONE);
        issue(CMD_STATE, 2'd0, tok_b, 16'sd0, DIR_NONE);
        issue(CMD_LEAVE, 2'd2, tok_b, 16'sd0, DIR_NONE);
        issue(CMD_LEAVE, 2'd2, tok_b, 16'sd0, DIR_NONE);
        issue(CMD_UNKNOWN_LAST, 2'd1, tok_a, 16'sd0, DIR_NONE);
        repeat (3) issue(CMD_TICK, 2'd0, tok_a, 16'sd0, DIR_NONE);

        // Random phases, each under its own register setting.
        for (int p = 0; p < 5; p++)
        begin
            wait_for_results();
            program_register(REG_SEAT_COUNT, 16'(phase_seats[p]));
            program_register(REG_TIMEOUT, 16'(phase_timeout[p]));
            foreach (token_pool[i])
                token_pool[i] = $urandom;
            idling = (p != 1);
            for (int n = 0; n < phase_items[p]; n++)
            begin
                // Halfway through, hold the sender until the pipeline has drained.
                if (n == phase_items[p] / 2)
                    wait_for_results();
                issue_random();
            end
        end

        // Longest timeout: the seat must survive an unbroken tick burst.
        wait_for_results();
        program_register(REG_SEAT_COUNT, 16'd2);
        program_register(REG_TIMEOUT, TIMEOUT_LONGEST);
        idling = 1'b0;
        issue(CMD_JOIN, 2'd1, tok_a, 16'sd0, DIR_NONE);
        repeat (LONG_TICK_BURST) issue(CMD_TICK, 2'd0, tok_a, 16'sd0, DIR_NONE);
        idling = 1'b1;
        issue(CMD_STATE, 2'd1, tok_a, 16'sd0, DIR_NONE);
        issue(CMD_PING, 2'd1, tok_a, 16'sd0, DIR_NONE);

        // Let the last results drain, then let the clock run on before the summary.
        wait_for_results();
        repeat (10) @(posedge clk);

        $display("Ran %0d requests under %0d register writes, %0d results checked,",
                 requests, settings, sb.results_checked);
        $display("with %0d seats freed by silence and %0d button presses taken.",
                 sb.releases, sb.presses_taken);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("seat_lease_table_test: PASS");
        else
            $display("seat_lease_table_test: FAIL");
        $finish;
    end

endmodule
